>>> rtl/core/tsd_pkg.sv
package tsd_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;

  localparam int VIDX_W  = $clog2(MAX_VERTICES);
  localparam int EIDX_W  = $clog2(MAX_EDGES);
  localparam int VCNT_W  = VIDX_W + 1;
  localparam int EFILL_W = EIDX_W + 1;
  localparam int FIELD_W = 7;

  // Saved walk frame: vertex, next edge, next edge valid.
  localparam int FRAME_W = VIDX_W + EIDX_W + 1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ADD,
    CMD_LINK,
    CMD_ROOT_SKIP,
    CMD_PUSH_ROOT,
    CMD_LOAD_EDGE,
    CMD_READ_EDGE,
    CMD_FINISH,
    CMD_POP,
    CMD_EDGE_SKIP,
    CMD_PUSH_CHILD,
    CMD_READ_COLOR,
    CMD_CHECK_COLOR,
    CMD_EMIT_READ,
    CMD_EMIT_OUT,
    CMD_EMIT_CYCLE
  } cmd_e;

  typedef struct packed {
    logic need_link;
    logic root_done;
    logic root_visited;
    logic top_ok;
    logic stack_empty;
    logic edge_skip;
    logic edge_white;
    logic cycle;
    logic fin_last;
  } status_t;

endpackage

>>> rtl/core/tsd_ctrl.sv
module tsd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             action_i,
  input  tsd_pkg::status_t status_i,
  output tsd_pkg::cmd_e    cmd_o,
  output logic             busy
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINK,
    ST_ROOT,
    ST_LOAD,
    ST_STEP,
    ST_POP,
    ST_EDGE,
    ST_COLOR,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = tsd_pkg::CMD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start && !busy_q) begin
          if (!action_i) begin
            cmd_o = tsd_pkg::CMD_ADD;
            if (status_i.need_link) state_d = ST_LINK;
          end else begin
            state_d = ST_ROOT;
          end
        end
      end
      ST_LINK: begin
        cmd_o   = tsd_pkg::CMD_LINK;
        state_d = ST_IDLE;
      end
      ST_ROOT: begin
        if (status_i.root_done) begin
          if (status_i.cycle) begin
            cmd_o   = tsd_pkg::CMD_EMIT_CYCLE;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end else if (status_i.root_visited) begin
          cmd_o = tsd_pkg::CMD_ROOT_SKIP;
        end else begin
          cmd_o   = tsd_pkg::CMD_PUSH_ROOT;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o   = tsd_pkg::CMD_LOAD_EDGE;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (status_i.top_ok) begin
          cmd_o   = tsd_pkg::CMD_READ_EDGE;
          state_d = ST_EDGE;
        end else begin
          cmd_o   = tsd_pkg::CMD_FINISH;
          state_d = status_i.stack_empty ? ST_ROOT : ST_POP;
        end
      end
      ST_POP: begin
        cmd_o   = tsd_pkg::CMD_POP;
        state_d = ST_STEP;
      end
      ST_EDGE: begin
        if (status_i.edge_skip) begin
          cmd_o   = tsd_pkg::CMD_EDGE_SKIP;
          state_d = ST_STEP;
        end else if (status_i.edge_white) begin
          cmd_o   = tsd_pkg::CMD_PUSH_CHILD;
          state_d = ST_LOAD;
        end else begin
          cmd_o   = tsd_pkg::CMD_READ_COLOR;
          state_d = ST_COLOR;
        end
      end
      ST_COLOR: begin
        cmd_o   = tsd_pkg::CMD_CHECK_COLOR;
        state_d = ST_STEP;
      end
      ST_EMIT_RD: begin
        cmd_o   = tsd_pkg::CMD_EMIT_READ;
        state_d = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        cmd_o   = tsd_pkg::CMD_EMIT_OUT;
        state_d = status_i.fin_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

>>> rtl/core/tsd_datapath.sv
module tsd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsd_pkg::FIELD_W-1:0]   cfg_data_i,
  input  logic [tsd_pkg::FIELD_W-1:0]   edge_from_i,
  input  logic [tsd_pkg::FIELD_W-1:0]   edge_to_i,
  input  tsd_pkg::cmd_e                 cmd_i,
  output tsd_pkg::status_t              status_o,
  output logic                          strobe_o,
  output logic [tsd_pkg::FIELD_W-1:0]   vertex_o,
  output logic                          cycle_found_o,
  output logic                          bad_edge_o,
  output logic                          last_o
);

  localparam int VW = tsd_pkg::VIDX_W;
  localparam int EW = tsd_pkg::EIDX_W;
  localparam int NV = tsd_pkg::MAX_VERTICES;
  localparam int NE = tsd_pkg::MAX_EDGES;

  // Control state.
  logic [tsd_pkg::FIELD_W-1:0] vcount_q;
  logic [tsd_pkg::EFILL_W-1:0] fill_q;
  logic                        dropped_q, cycle_q;
  logic [NV-1:0]               head_valid_q, visited_q;
  logic [tsd_pkg::VCNT_W-1:0]  root_q, fin_cnt_q;
  logic [VW-1:0]               sp_q;
  logic [VW-1:0]               top_v_q;
  logic [EW-1:0]               top_e_q;
  logic                        top_ok_q;
  logic [EW-1:0]               link_e_q;
  logic                        strobe_q;

  // Memory read registers.
  logic [EW-1:0]                  head_rd_q, tail_rd_q;
  logic [VW-1:0]                  tgt_rd_q;
  logic [EW:0]                    nxt_rd_q;
  logic                           black_rd_q;
  logic [tsd_pkg::FRAME_W-1:0]    stk_rd_q;
  logic [VW-1:0]                  fin_rd_q;

  // Memories.
  logic [EW-1:0]               head_mem  [NV];
  logic [EW-1:0]               tail_mem  [NV];
  logic [VW-1:0]               tgt_mem   [NE];
  logic [EW:0]                 nxt_mem   [NE];
  logic                        black_mem [NV];
  logic [tsd_pkg::FRAME_W-1:0] stack_mem [NV];
  logic [VW-1:0]               fin_mem   [NV];

  // Output payload.
  logic [tsd_pkg::FIELD_W-1:0] vertex_q;
  logic                        cycle_out_q, bad_out_q, last_out_q;

  logic [tsd_pkg::VCNT_W-1:0]  n_eff;
  logic [tsd_pkg::FIELD_W-1:0] from_m1, to_m1;
  logic [VW-1:0]               src_idx, dst_idx;
  logic                        edge_ok;
  logic [VW-1:0]               root_idx;
  logic [VW-1:0]               head_ra;
  logic                        black_we, black_wd;
  logic [VW-1:0]               black_wa;
  logic                        nxt_we;
  logic [EW-1:0]               nxt_wa;
  logic [EW:0]                 nxt_wd;
  logic [tsd_pkg::VCNT_W-1:0]  fin_m1;
  logic                        run_clear;

  always_comb begin
    if (vcount_q == '0) begin
      n_eff = tsd_pkg::VCNT_W'(1);
    end else if (vcount_q > tsd_pkg::FIELD_W'(NV)) begin
      n_eff = tsd_pkg::VCNT_W'(NV);
    end else begin
      n_eff = tsd_pkg::VCNT_W'(vcount_q);
    end
  end

  assign from_m1  = edge_from_i - tsd_pkg::FIELD_W'(1);
  assign to_m1    = edge_to_i - tsd_pkg::FIELD_W'(1);
  assign src_idx  = from_m1[VW-1:0];
  assign dst_idx  = to_m1[VW-1:0];
  assign edge_ok  = (edge_from_i != '0) && (edge_from_i <= tsd_pkg::FIELD_W'(n_eff))
                 && (edge_to_i != '0) && (edge_to_i <= tsd_pkg::FIELD_W'(n_eff))
                 && (fill_q != tsd_pkg::EFILL_W'(NE));
  assign root_idx = root_q[VW-1:0];
  assign fin_m1   = fin_cnt_q - tsd_pkg::VCNT_W'(1);

  assign status_o.need_link    = edge_ok && head_valid_q[src_idx];
  assign status_o.root_done    = (root_q == n_eff);
  assign status_o.root_visited = visited_q[root_idx];
  assign status_o.top_ok       = top_ok_q;
  assign status_o.stack_empty  = (sp_q == '0);
  assign status_o.edge_skip    = ({1'b0, tgt_rd_q} >= n_eff);
  assign status_o.edge_white   = !visited_q[tgt_rd_q];
  assign status_o.cycle        = cycle_q;
  assign status_o.fin_last     = (fin_cnt_q == '0);

  // The last result of a run also returns the graph state to empty.
  assign run_clear = (cmd_i == tsd_pkg::CMD_EMIT_CYCLE)
                  || ((cmd_i == tsd_pkg::CMD_EMIT_OUT) && (fin_cnt_q == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q     <= tsd_pkg::FIELD_W'(NV);
      fill_q       <= '0;
      dropped_q    <= 1'b0;
      cycle_q      <= 1'b0;
      head_valid_q <= '0;
      visited_q    <= '0;
      root_q       <= '0;
      fin_cnt_q    <= '0;
      sp_q         <= '0;
      top_v_q      <= '0;
      top_e_q      <= '0;
      top_ok_q     <= 1'b0;
      link_e_q     <= '0;
      strobe_q     <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      if (cfg_we_i) vcount_q <= cfg_data_i;
      unique case (cmd_i)
        tsd_pkg::CMD_ADD: begin
          if (edge_ok) begin
            fill_q                <= fill_q + tsd_pkg::EFILL_W'(1);
            link_e_q              <= fill_q[EW-1:0];
            head_valid_q[src_idx] <= 1'b1;
          end else begin
            dropped_q <= 1'b1;
          end
        end
        tsd_pkg::CMD_ROOT_SKIP: begin
          root_q <= root_q + tsd_pkg::VCNT_W'(1);
        end
        tsd_pkg::CMD_PUSH_ROOT: begin
          top_v_q             <= root_idx;
          top_ok_q            <= head_valid_q[root_idx];
          visited_q[root_idx] <= 1'b1;
          root_q              <= root_q + tsd_pkg::VCNT_W'(1);
        end
        tsd_pkg::CMD_LOAD_EDGE: begin
          top_e_q <= head_rd_q;
        end
        tsd_pkg::CMD_FINISH: begin
          fin_cnt_q <= fin_cnt_q + tsd_pkg::VCNT_W'(1);
          if (sp_q != '0) sp_q <= sp_q - VW'(1);
        end
        tsd_pkg::CMD_POP: begin
          {top_v_q, top_e_q, top_ok_q} <= stk_rd_q;
        end
        tsd_pkg::CMD_EDGE_SKIP, tsd_pkg::CMD_READ_COLOR: begin
          top_e_q  <= nxt_rd_q[EW-1:0];
          top_ok_q <= nxt_rd_q[EW];
        end
        tsd_pkg::CMD_PUSH_CHILD: begin
          sp_q                <= sp_q + VW'(1);
          top_v_q             <= tgt_rd_q;
          top_ok_q            <= head_valid_q[tgt_rd_q];
          visited_q[tgt_rd_q] <= 1'b1;
        end
        tsd_pkg::CMD_CHECK_COLOR: begin
          // A visited vertex that has not finished is on the walk path.
          if (!black_rd_q) cycle_q <= 1'b1;
        end
        tsd_pkg::CMD_EMIT_READ: begin
          fin_cnt_q <= fin_m1;
        end
        tsd_pkg::CMD_EMIT_OUT, tsd_pkg::CMD_EMIT_CYCLE: begin
          strobe_q <= 1'b1;
        end
        default: begin
        end
      endcase
      if (run_clear) begin
        fill_q       <= '0;
        dropped_q    <= 1'b0;
        cycle_q      <= 1'b0;
        head_valid_q <= '0;
        visited_q    <= '0;
        root_q       <= '0;
        fin_cnt_q    <= '0;
        sp_q         <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == tsd_pkg::CMD_EMIT_CYCLE) begin
      vertex_q    <= '0;
      cycle_out_q <= 1'b1;
      bad_out_q   <= dropped_q;
      last_out_q  <= 1'b1;
    end else if (cmd_i == tsd_pkg::CMD_EMIT_OUT) begin
      vertex_q    <= tsd_pkg::FIELD_W'(fin_rd_q) + tsd_pkg::FIELD_W'(1);
      cycle_out_q <= 1'b0;
      bad_out_q   <= dropped_q;
      last_out_q  <= (fin_cnt_q == '0);
    end
  end

  // Adjacency list heads and tails.
  assign head_ra = (cmd_i == tsd_pkg::CMD_PUSH_ROOT) ? root_idx : tgt_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i == tsd_pkg::CMD_ADD && edge_ok && !head_valid_q[src_idx]) begin
      head_mem[src_idx] <= fill_q[EW-1:0];
    end
    if (cmd_i == tsd_pkg::CMD_PUSH_ROOT || cmd_i == tsd_pkg::CMD_PUSH_CHILD) begin
      head_rd_q <= head_mem[head_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == tsd_pkg::CMD_ADD) begin
      if (edge_ok) tail_mem[src_idx] <= fill_q[EW-1:0];
      tail_rd_q <= tail_mem[src_idx];
    end
  end

  // Edge store: target and link to the next edge of the same source.
  always_ff @(posedge clk_i) begin
    if (cmd_i == tsd_pkg::CMD_ADD && edge_ok) tgt_mem[fill_q[EW-1:0]] <= dst_idx;
    if (cmd_i == tsd_pkg::CMD_READ_EDGE) tgt_rd_q <= tgt_mem[top_e_q];
  end

  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = fill_q[EW-1:0];
    nxt_wd = {1'b0, fill_q[EW-1:0]};
    if (cmd_i == tsd_pkg::CMD_ADD && edge_ok) begin
      nxt_we = 1'b1;
    end else if (cmd_i == tsd_pkg::CMD_LINK) begin
      nxt_we = 1'b1;
      nxt_wa = tail_rd_q;
      nxt_wd = {1'b1, link_e_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (cmd_i == tsd_pkg::CMD_READ_EDGE) nxt_rd_q <= nxt_mem[top_e_q];
  end

  // Finished flag per vertex; a visited vertex without it is grey.
  always_comb begin
    black_we = 1'b0;
    black_wa = root_idx;
    black_wd = 1'b0;
    unique case (cmd_i)
      tsd_pkg::CMD_PUSH_ROOT: begin
        black_we = 1'b1;
      end
      tsd_pkg::CMD_PUSH_CHILD: begin
        black_we = 1'b1;
        black_wa = tgt_rd_q;
      end
      tsd_pkg::CMD_FINISH: begin
        black_we = 1'b1;
        black_wa = top_v_q;
        black_wd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (black_we) black_mem[black_wa] <= black_wd;
    if (cmd_i == tsd_pkg::CMD_READ_COLOR) black_rd_q <= black_mem[tgt_rd_q];
  end

  // Saved frames of the walk below the current vertex.
  always_ff @(posedge clk_i) begin
    if (cmd_i == tsd_pkg::CMD_PUSH_CHILD) begin
      stack_mem[sp_q] <= {top_v_q, nxt_rd_q[EW-1:0], nxt_rd_q[EW]};
    end
    if (cmd_i == tsd_pkg::CMD_FINISH) stk_rd_q <= stack_mem[sp_q - VW'(1)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == tsd_pkg::CMD_FINISH) fin_mem[fin_cnt_q[VW-1:0]] <= top_v_q;
    if (cmd_i == tsd_pkg::CMD_EMIT_READ) fin_rd_q <= fin_mem[fin_m1[VW-1:0]];
  end

  assign strobe_o      = strobe_q;
  assign vertex_o      = vertex_q;
  assign cycle_found_o = cycle_out_q;
  assign bad_edge_o    = bad_out_q;
  assign last_o        = last_out_q;

endmodule

>>> rtl/core/topological_sort_dfs.sv
// Topological sort of a directed graph by depth-first search.
// Commands are taken on start while busy is low. An edge command
// (action_i low) loads one edge into the adjacency store, with an extra
// link step when its source already has a list, since the old tail must
// be linked to the new edge. A bad or excess edge is dropped and
// remembered for the bad_edge flag. A run command (action_i high) walks
// the graph: each vertex is pushed, loads its first edge and finishes,
// then the walk returns to its parent; each edge is read, and a vertex
// already seen has its colour checked; every root is checked. It then
// gives one result per vertex, each read from the finish list and then
// on the result ports for one cycle with strobe high and last high on
// the final one; a cyclic graph gives one result with cycle_found set
// instead. The receiver cannot stall, so every strobe is a completed
// transfer. The final result clears the graph; vertex_count is kept.
// vertex_count is written through cfg_we_i and cfg_data_i; the user must
// do so only while busy is low, as the block does not enforce it. Reset
// empties the graph, sets vertex_count to 64 and needs no clearing pass.
module topological_sort_dfs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tsd_pkg::FIELD_W-1:0] cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action_i,
  input  logic [tsd_pkg::FIELD_W-1:0] edge_from_i,
  input  logic [tsd_pkg::FIELD_W-1:0] edge_to_i,
  output logic                        strobe,
  output logic [tsd_pkg::FIELD_W-1:0] vertex_o,
  output logic                        cycle_found_o,
  output logic                        bad_edge_o,
  output logic                        last_o
);

  tsd_pkg::cmd_e    cmd;
  tsd_pkg::status_t status;

  tsd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  tsd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .edge_from_i   (edge_from_i),
    .edge_to_i     (edge_to_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .strobe_o      (strobe),
    .vertex_o      (vertex_o),
    .cycle_found_o (cycle_found_o),
    .bad_edge_o    (bad_edge_o),
    .last_o        (last_o)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int MAXV = tsd_pkg::MAX_VERTICES;
  localparam int MAXE = tsd_pkg::MAX_EDGES;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS = 20;

  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef enum logic [1:0] {WHITE, GREY, BLACK} paint_e;

  typedef struct packed {
    logic       action;
    logic [6:0] src;
    logic [6:0] dst;
  } cmd_t;

  typedef struct packed {
    logic [6:0] vertex;
    logic       cycle;
    logic       bad;
    logic       last;
  } order_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [6:0] cfg_data_i = '0;
  logic       start = 1'b0;
  logic       busy;
  logic       action_i = 1'b0;
  logic [6:0] edge_from_i = '0;
  logic [6:0] edge_to_i = '0;
  logic       strobe;
  logic [6:0] vertex_o;
  logic       cycle_found_o;
  logic       bad_edge_o;
  logic       last_o;

  topological_sort_dfs dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .edge_from_i  (edge_from_i),
    .edge_to_i    (edge_to_i),
    .strobe       (strobe),
    .vertex_o     (vertex_o),
    .cycle_found_o(cycle_found_o),
    .bad_edge_o   (bad_edge_o),
    .last_o       (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Graph mirror kept in step with every accepted command.
  logic [6:0] count_reg = 7'd64;
  paint_e     paint [MAXV];
  int         first_edge [MAXV];
  int         final_edge [MAXV];
  bit         has_list [MAXV];
  logic [5:0] edge_dst [MAXE];
  int         edge_link [MAXE];
  bit         link_ok [MAXE];
  int         stored_edges;
  bit         saw_cycle;
  bit         saw_drop;

  cmd_t   pending [$];
  order_t order_due [$];
  cmd_t   cur_cmd;

  int gap_left = 0;
  bit idle_on = 1'b1;
  int mismatches = 0;
  int quiet_cycles = 0;
  int edge_items = 0;
  int run_items = 0;
  int cycle_reports = 0;
  int results_checked = 0;

  function automatic int active_count();
    int n;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > MAXV) n = MAXV;
    return n;
  endfunction

  function automatic void graph_clear();
    for (int v = 0; v < MAXV; v++) begin
      paint[v] = WHITE;
      has_list[v] = 1'b0;
    end
    stored_edges = 0;
    saw_cycle = 1'b0;
    saw_drop = 1'b0;
  endfunction

  function automatic void graph_add_edge(int f, int t);
    int n, e, s;
    n = active_count();
    edge_items++;
    if (f == 0 || f > n || t == 0 || t > n || stored_edges >= MAXE) begin
      saw_drop = 1'b1;
      return;
    end
    e = stored_edges++;
    s = f - 1;
    edge_dst[e] = 6'(t - 1);
    link_ok[e] = 1'b0;
    if (has_list[s]) begin
      edge_link[final_edge[s]] = e;
      link_ok[final_edge[s]] = 1'b1;
    end else begin
      first_edge[s] = e;
      has_list[s] = 1'b1;
    end
    final_edge[s] = e;
  endfunction

  // Depth-first walk; each frame keeps its vertex and the next edge to follow.
  function automatic void graph_sort_run();
    int     n, sp, top, e, w;
    int     frame_v [MAXV];
    int     frame_e [MAXV];
    bit     frame_ok [MAXV];
    int     finished [$];
    order_t res;
    n = active_count();
    sp = 0;
    run_items++;
    for (int r = 0; r < n; r++) begin
      if (paint[r] != WHITE) continue;
      paint[r] = GREY;
      frame_v[0] = r;
      frame_e[0] = first_edge[r];
      frame_ok[0] = has_list[r];
      sp = 1;
      while (sp > 0) begin
        top = sp - 1;
        if (frame_ok[top]) begin
          e = frame_e[top];
          w = edge_dst[e];
          frame_ok[top] = link_ok[e];
          frame_e[top] = edge_link[e];
          if (w < n) begin
            if (paint[w] == WHITE) begin
              paint[w] = GREY;
              frame_v[sp] = w;
              frame_e[sp] = first_edge[w];
              frame_ok[sp] = has_list[w];
              sp++;
            end else if (paint[w] == GREY) begin
              saw_cycle = 1'b1;
            end
          end
        end else begin
          paint[frame_v[top]] = BLACK;
          finished = {finished, frame_v[top]};
          sp--;
        end
      end
    end
    if (saw_cycle) begin
      res = '{vertex: 7'd0, cycle: 1'b1, bad: saw_drop, last: 1'b1};
      order_due = {order_due, res};
      cycle_reports++;
    end else begin
      for (int k = 0; k < finished.size(); k++) begin
        res.vertex = 7'(finished[finished.size() - 1 - k] + 1);
        res.cycle = 1'b0;
        res.bad = saw_drop;
        res.last = (k == finished.size() - 1);
        order_due = {order_due, res};
      end
    end
    graph_clear();
  endfunction

  function automatic void queue_edge(int f, int t);
    cmd_t c;
    c = '{action: ACT_EDGE, src: 7'(f), dst: 7'(t)};
    pending = {pending, c};
  endfunction

  // Endpoint fields are ignored on a run but still get random content.
  function automatic void queue_run();
    cmd_t c;
    c.action = ACT_RUN;
    c.src = 7'($urandom_range(0, 127));
    c.dst = 7'($urandom_range(0, 127));
    pending = {pending, c};
  endfunction

  function automatic void report_mismatch(string msg);
    if (mismatches < 10) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endfunction

  // Driver: a command is taken on a rising edge with start high and busy low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        if (cur_cmd.action == ACT_RUN) graph_sort_run();
        else graph_add_edge(cur_cmd.src, cur_cmd.dst);
      end
      if (!(start && busy)) begin
        if (gap_left > 0 && idle_on) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending.size() > 0) begin
          cur_cmd = pending.pop_front();
          start <= 1'b1;
          action_i <= cur_cmd.action;
          edge_from_i <= cur_cmd.src;
          edge_to_i <= cur_cmd.dst;
          if (idle_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 14);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is a completed transfer.
  always @(posedge clk_i) begin
    order_t got, want;
    if (rst_ni && strobe) begin
      got = {vertex_o, cycle_found_o, bad_edge_o, last_o};
      if (order_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result vertex %0d cycle %0b bad %0b last %0b",
                                  got.vertex, got.cycle, got.bad, got.last));
      end else begin
        want = order_due.pop_front();
        results_checked++;
        if (got.vertex !== want.vertex || got.cycle !== want.cycle ||
            got.bad !== want.bad || got.last !== want.last) begin
          report_mismatch($sformatf(
            "expected vertex %0d cycle %0b bad %0b last %0b, got %0d %0b %0b %0b",
            want.vertex, want.cycle, want.bad, want.last,
            got.vertex, got.cycle, got.bad, got.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending.size() != 0 || start || busy || order_due.size() != 0);
  endtask

  // An edge command gives no result, so allow the block to finish linking first.
  task automatic program_count(input logic [6:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_reg = value;
    #1;
  endtask

  initial begin
    int made, edges, nn, f, t, kind;
    bit dag_only;
    graph_clear();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    #1;

    // Reset width of 64 vertices, extreme endpoints and dropped edges.
    queue_edge(64, 1);
    queue_edge(1, 2);
    queue_edge(2, 3);
    queue_edge(1, 3);
    queue_edge(0, 5);
    queue_edge(5, 0);
    queue_edge(65, 1);
    queue_edge(127, 127);
    queue_edge(1, 64);
    queue_run();

    // A three-vertex loop plus a self loop.
    program_count(7'd4);
    queue_edge(1, 2);
    queue_edge(2, 3);
    queue_edge(3, 1);
    queue_edge(4, 4);
    queue_run();

    // Zero acts as one vertex; an empty graph and then one dropped edge.
    program_count(7'd0);
    queue_run();
    queue_edge(2, 1);
    queue_run();

    // Load at full width, then shrink before the run.
    program_count(7'd127);
    queue_edge(10, 50);
    queue_edge(50, 5);
    queue_edge(3, 60);
    queue_edge(3, 2);
    queue_edge(5, 9);
    program_count(7'd8);
    queue_run();

    program_count(7'd65);
    queue_edge(64, 64);
    queue_run();

    // Overfill the edge store with an acyclic graph.
    program_count(7'd12);
    idle_on = $urandom_range(0, 1);
    for (int i = 0; i < MAXE + 2; i++) begin
      f = $urandom_range(1, 11);
      queue_edge(f, $urandom_range(f + 1, 12));
    end
    queue_run();

    // The batch that reaches the item target runs without idling.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      do begin
        @(posedge clk_i);
        #1;
      end while (pending.size() != 0);
      edges = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      idle_on = (made + edges + 1 < RANDOM_ITEMS) && ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: program_count(7'($urandom_range(2, 10)));
          6, 7:             program_count(7'($urandom_range(11, 40)));
          8:                program_count(7'd64);
          default:          program_count(7'($urandom_range(0, 127)));
        endcase
      end
      nn = active_count();
      dag_only = ($urandom_range(0, 9) < 7);
      for (int i = 0; i < edges; i++) begin
        kind = $urandom_range(0, 19);
        if (nn >= 2 && (dag_only ? kind < 19 : kind < 10)) begin
          f = $urandom_range(1, nn - 1);
          t = $urandom_range(f + 1, nn);
        end else if (!dag_only && kind < 17) begin
          f = $urandom_range(1, nn);
          t = $urandom_range(1, nn);
        end else begin
          f = $urandom_range(0, 127);
          t = $urandom_range(0, 127);
        end
        queue_edge(f, t);
      end
      if ($urandom_range(0, 9) == 0) program_count(7'($urandom_range(1, nn)));
      queue_run();
      made += edges + 1;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (order_due.size() != 0) begin
      $display("%0d expected results never arrived", order_due.size());
      mismatches += order_due.size();
    end
    $display("Checked %0d ordered vertices from %0d sorts (%0d with a loop) over %0d edge loads,",
             results_checked, run_items, cycle_reports, edge_items);
    $display("widths 1 to 64 with out-of-range settings, a full edge store; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/tsd_pkg.sv
rtl/core/tsd_ctrl.sv
rtl/core/tsd_datapath.sv
rtl/core/topological_sort_dfs.sv
tb/testbench.sv
